/* src/tws_pkg.sv */
// ----------------------------------------------------------------------------
// Two-voice wavetable sequencer package
// Shared types, field widths, request and register codes, and defaults.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int SONG_DEPTH_DEF      = 256;
  localparam int WAVE_LENGTH_DEF     = 64;
  localparam int NUM_INSTRUMENTS_DEF = 3;
  localparam int NUM_BUTTONS_DEF     = 4;

  localparam int REQ_W     = 3;
  localparam int BTN_W     = 4;
  localparam int NIDX_W    = 8;
  localparam int PERIOD_W  = 20;
  localparam int BEATS_W   = 8;
  localparam int INST_W    = 2;
  localparam int WIDX_W    = 6;
  localparam int SAMPLE_W  = 12;
  localparam int LEN_W     = 9;
  localparam int DBN_W     = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [LEN_W-1:0] SONG_LEN_RST = LEN_W'(1);
  localparam logic [DBN_W-1:0] DEBOUNCE_RST = DBN_W'(5);

  localparam logic [REQ_W-1:0] REQ_BEAT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_V1    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_V2    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_NOTE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_WAVE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SONG1_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SONG2_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd2;

  localparam int BTN_PLAY    = 0;
  localparam int BTN_RESTART = 1;
  localparam int BTN_INSTR   = 2;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [BTN_W-1:0]    buttons;
    logic                note_voice;
    logic [NIDX_W-1:0]   note_index;
    logic [PERIOD_W-1:0] note_period;
    logic [BEATS_W-1:0]  note_beats;
    logic [INST_W-1:0]   wave_instrument;
    logic [WIDX_W-1:0]   wave_index;
    logic [SAMPLE_W-1:0] wave_sample;
  } in_beat_t;

  typedef struct packed {
    logic                dac_valid;
    logic [SAMPLE_W-1:0] dac_value;
    logic                reload1_valid;
    logic [PERIOD_W-1:0] reload1_value;
    logic                reload2_valid;
    logic [PERIOD_W-1:0] reload2_value;
    logic                play_on;
    logic [INST_W-1:0]   instrument_now;
  } out_beat_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [BEATS_W-1:0]  beats;
  } note_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

/* src/tws_song_mem.sv */
// ----------------------------------------------------------------------------
// Song note memory
// One write port and two registered read ports holding period and beats.
// ----------------------------------------------------------------------------
module tws_song_mem #(
  parameter int DEPTH = tws_pkg::SONG_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [tws_pkg::addr_w(DEPTH)-1:0]    waddr,
  input  tws_pkg::note_t                       wdata,
  input  logic                                 re,
  input  logic [tws_pkg::addr_w(DEPTH)-1:0]    raddr_a,
  input  logic [tws_pkg::addr_w(DEPTH)-1:0]    raddr_b,
  output tws_pkg::note_t                       rdata_a,
  output tws_pkg::note_t                       rdata_b
);
  import tws_pkg::*;

  note_t mem [DEPTH];
  note_t rd_a_r;
  note_t rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

/* src/two_voice_wavetable_sequencer.sv */
// ----------------------------------------------------------------------------
// Two-voice wavetable sequencer
// Path: an accepted item and the registered read of the note and wave memories
// are held in the first stage, then the state update is registered into the result
// beat when the output is free; no new item is taken while the first stage is full.
// Reset: synchronous, active low; control state clears to its reset value,
// the note and wave memories hold whatever was last written.
// ----------------------------------------------------------------------------
module two_voice_wavetable_sequencer #(
  parameter int SONG_DEPTH      = tws_pkg::SONG_DEPTH_DEF,
  parameter int WAVE_LENGTH     = tws_pkg::WAVE_LENGTH_DEF,
  parameter int NUM_INSTRUMENTS = tws_pkg::NUM_INSTRUMENTS_DEF,
  parameter int NUM_BUTTONS     = tws_pkg::NUM_BUTTONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tws_pkg::in_beat_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tws_pkg::out_beat_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tws_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tws_pkg::*;

  localparam int POS_W      = addr_w(SONG_DEPTH);
  localparam int CW         = (LEN_W > POS_W + 1) ? LEN_W : POS_W + 1;
  localparam int NI_W       = (NIDX_W > POS_W) ? NIDX_W : POS_W;
  localparam int PH_W       = addr_w(WAVE_LENGTH);
  localparam int WI_W       = (WIDX_W > PH_W) ? WIDX_W : PH_W;
  localparam int WAVE_DEPTH = NUM_INSTRUMENTS * WAVE_LENGTH;
  localparam int WA_W       = addr_w(WAVE_DEPTH);
  localparam int MW         = WA_W + 2;
  localparam int BX_W       = (NUM_BUTTONS > BTN_W) ? NUM_BUTTONS : BTN_W;

  typedef struct packed {
    logic [POS_W-1:0]    pos;
    logic [BEATS_W-1:0]  beats;
    logic                rv;
    logic [PERIOD_W-1:0] reload;
  } voice_t;

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos,
                                                input logic [LEN_W-1:0] len);
    logic [CW-1:0] eff;
    logic [CW-1:0] inc;
    eff = CW'(len);
    if (len == '0) begin
      eff = CW'(1);
    end else if (CW'(len) > CW'(SONG_DEPTH)) begin
      eff = CW'(SONG_DEPTH);
    end
    inc = CW'(pos) + CW'(1);
    return (inc >= eff) ? '0 : inc[POS_W-1:0];
  endfunction

  function automatic logic [PH_W-1:0] next_phase(input logic [PH_W-1:0] ph);
    logic [PH_W:0] inc;
    inc = {1'b0, ph} + (PH_W+1)'(1);
    return (inc >= (PH_W+1)'(WAVE_LENGTH)) ? '0 : inc[PH_W-1:0];
  endfunction

  function automatic voice_t voice_step(input logic start, input logic adv,
                                        input logic [BEATS_W-1:0] beats,
                                        input logic [POS_W-1:0] pos,
                                        input logic [POS_W-1:0] nxt,
                                        input note_t ea, input note_t eb);
    voice_t v;
    logic [BEATS_W-1:0] b;
    v.pos    = pos;
    v.beats  = beats;
    v.rv     = 1'b0;
    v.reload = '0;
    if (start) begin
      v.pos    = '0;
      v.beats  = ea.beats;
      v.rv     = 1'b1;
      v.reload = ea.period - PERIOD_W'(1);
    end
    if (adv) begin
      b       = v.beats - BEATS_W'(1);
      v.beats = b;
      if (b == '0) begin
        v.pos    = nxt;
        v.beats  = eb.beats;
        v.rv     = 1'b1;
        v.reload = eb.period - PERIOD_W'(1);
      end
    end
    return v;
  endfunction

  logic [LEN_W-1:0]    len1_r, len2_r;
  logic [DBN_W-1:0]    dbn_r;
  logic                play_r, started_r;
  logic [INST_W-1:0]   inst_r;
  logic [DBN_W-1:0]    cd_r [NUM_BUTTONS];
  logic [POS_W-1:0]    pos1_r, pos2_r;
  logic [BEATS_W-1:0]  beats1_r, beats2_r;
  logic [PH_W-1:0]     ph1_r, ph2_r;
  logic [SAMPLE_W-1:0] smp1_r, smp2_r;

  logic                s1_vld_r;
  logic [REQ_W-1:0]    s1_req_r;
  logic                s1_start_r, s1_adv_r;
  logic [POS_W-1:0]    s1_nxt1_r, s1_nxt2_r;

  logic                out_vld_r;
  out_beat_t           out_r;

  logic                acc, s2_go;
  logic [DBN_W-1:0]    cd_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] fire;
  logic [BX_W-1:0]     btn_ext, fire_ext;
  logic                play_nxt, started_b, start_b;
  logic [INST_W-1:0]   inst_nxt;
  logic [INST_W:0]     inst_inc;
  logic [POS_W-1:0]    nxt1, nxt2;
  logic [PH_W-1:0]     ph_sel_nxt;
  logic [WA_W-1:0]     wave_raddr, wave_waddr;
  logic [MW-1:0]       wave_raddr_w, wave_waddr_w;
  logic [WI_W-1:0]     widx_ext;
  logic                wave_we;
  logic [NI_W-1:0]     nidx_ext;
  logic                note_ok, we1, we2;
  note_t               note_wr;
  note_t               s1a, s1b, s2a, s2b;
  logic [SAMPLE_W-1:0] wave_mem [WAVE_DEPTH];
  logic [SAMPLE_W-1:0] wave_rd_r;

  voice_t              v1, v2;
  logic [SAMPLE_W-1:0] smp1_nxt, smp2_nxt;
  logic [SAMPLE_W:0]   mix;
  out_beat_t           out_nxt;

  assign acc       = in_valid & ~in_stall;
  assign in_stall  = s1_vld_r;
  assign s2_go     = s1_vld_r & (~out_vld_r | ~out_stall);
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    btn_ext = BX_W'(in_data.buttons);
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      cd_nxt[i] = cd_r[i];
      fire[i]   = 1'b0;
      if (i < BTN_W && btn_ext[i]) begin
        cd_nxt[i] = dbn_r;
      end
      if (cd_nxt[i] != '0) begin
        cd_nxt[i] = cd_nxt[i] - DBN_W'(1);
        fire[i]   = (cd_nxt[i] == '0);
      end
    end
    fire_ext  = BX_W'(fire);
    play_nxt  = play_r ^ fire_ext[BTN_PLAY];
    started_b = started_r & ~fire_ext[BTN_RESTART];
    inst_inc  = {1'b0, inst_r} + (INST_W+1)'(1);
    inst_nxt  = inst_r;
    if (fire_ext[BTN_INSTR]) begin
      inst_nxt = (inst_inc >= (INST_W+1)'(NUM_INSTRUMENTS)) ? '0 : inst_inc[INST_W-1:0];
    end
    start_b = play_nxt & ~started_b;
    nxt1    = next_pos(start_b ? '0 : pos1_r, len1_r);
    nxt2    = next_pos(start_b ? '0 : pos2_r, len2_r);
  end

  always_comb begin
    ph_sel_nxt   = next_phase((in_data.req_type == REQ_V2) ? ph2_r : ph1_r);
    wave_raddr_w = MW'(inst_r) * MW'(WAVE_LENGTH) + MW'(ph_sel_nxt);
    wave_raddr   = wave_raddr_w[WA_W-1:0];
    widx_ext     = WI_W'(in_data.wave_index);
    wave_waddr_w = MW'(in_data.wave_instrument) * MW'(WAVE_LENGTH) + MW'(widx_ext);
    wave_waddr   = wave_waddr_w[WA_W-1:0];
    wave_we      = acc && (in_data.req_type == REQ_WAVE)
                   && ((INST_W+1)'(in_data.wave_instrument) < (INST_W+1)'(NUM_INSTRUMENTS))
                   && ((WI_W+1)'(widx_ext) < (WI_W+1)'(WAVE_LENGTH));
    nidx_ext     = NI_W'(in_data.note_index);
    note_ok      = (NI_W+1)'(nidx_ext) < (NI_W+1)'(SONG_DEPTH);
    we1          = acc && (in_data.req_type == REQ_NOTE) && note_ok && !in_data.note_voice;
    we2          = acc && (in_data.req_type == REQ_NOTE) && note_ok && in_data.note_voice;
    note_wr      = '{period: in_data.note_period, beats: in_data.note_beats};
  end

  tws_song_mem #(.DEPTH(SONG_DEPTH)) u_song1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (nidx_ext[POS_W-1:0]),
    .wdata   (note_wr),
    .re      (acc),
    .raddr_a ('0),
    .raddr_b (nxt1),
    .rdata_a (s1a),
    .rdata_b (s1b)
  );

  tws_song_mem #(.DEPTH(SONG_DEPTH)) u_song2 (
    .clk     (clk),
    .we      (we2),
    .waddr   (nidx_ext[POS_W-1:0]),
    .wdata   (note_wr),
    .re      (acc),
    .raddr_a ('0),
    .raddr_b (nxt2),
    .rdata_a (s2a),
    .rdata_b (s2b)
  );

  always_ff @(posedge clk) begin
    if (wave_we) begin
      wave_mem[wave_waddr] <= in_data.wave_sample;
    end
    if (acc) begin
      wave_rd_r <= wave_mem[wave_raddr];
    end
  end

  always_comb begin
    v1       = voice_step(1'b0, 1'b0, beats1_r, pos1_r, s1_nxt1_r, s1a, s1b);
    v2       = voice_step(1'b0, 1'b0, beats2_r, pos2_r, s1_nxt2_r, s2a, s2b);
    smp1_nxt = smp1_r;
    smp2_nxt = smp2_r;
    out_nxt  = '0;
    case (s1_req_r)
      REQ_BEAT: begin
        v1 = voice_step(s1_start_r, s1_adv_r, beats1_r, pos1_r, s1_nxt1_r, s1a, s1b);
        v2 = voice_step(s1_start_r, s1_adv_r, beats2_r, pos2_r, s1_nxt2_r, s2a, s2b);
      end
      REQ_V1: begin
        smp1_nxt = wave_rd_r;
      end
      REQ_V2: begin
        smp2_nxt = wave_rd_r >> 1;
      end
      default: begin
      end
    endcase
    mix                    = {1'b0, smp1_nxt} + {1'b0, smp2_nxt};
    out_nxt.dac_valid      = (s1_req_r == REQ_V1) || (s1_req_r == REQ_V2);
    out_nxt.dac_value      = (out_nxt.dac_valid && play_r) ? mix[SAMPLE_W:1] : '0;
    out_nxt.reload1_valid  = v1.rv;
    out_nxt.reload1_value  = v1.rv ? v1.reload : '0;
    out_nxt.reload2_valid  = v2.rv;
    out_nxt.reload2_value  = v2.rv ? v2.reload : '0;
    out_nxt.play_on        = play_r;
    out_nxt.instrument_now = inst_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len1_r    <= SONG_LEN_RST;
      len2_r    <= SONG_LEN_RST;
      dbn_r     <= DEBOUNCE_RST;
      play_r    <= 1'b1;
      started_r <= 1'b0;
      inst_r    <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        cd_r[i] <= '0;
      end
      pos1_r    <= '0;
      pos2_r    <= '0;
      beats1_r  <= '0;
      beats2_r  <= '0;
      ph1_r     <= '0;
      ph2_r     <= '0;
      smp1_r    <= '0;
      smp2_r    <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SONG1_LEN: len1_r <= cfg_data[LEN_W-1:0];
          CFG_SONG2_LEN: len2_r <= cfg_data[LEN_W-1:0];
          CFG_DEBOUNCE:  dbn_r  <= cfg_data[DBN_W-1:0];
          default: begin
          end
        endcase
      end
      if (acc) begin
        s1_vld_r <= 1'b1;
        if (in_data.req_type == REQ_BEAT) begin
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            cd_r[i] <= cd_nxt[i];
          end
          play_r    <= play_nxt;
          started_r <= started_b | play_nxt;
          inst_r    <= inst_nxt;
        end
        if (in_data.req_type == REQ_V1) begin
          ph1_r <= ph_sel_nxt;
        end
        if (in_data.req_type == REQ_V2) begin
          ph2_r <= ph_sel_nxt;
        end
      end else if (s2_go) begin
        s1_vld_r <= 1'b0;
      end
      if (s2_go) begin
        pos1_r    <= v1.pos;
        pos2_r    <= v2.pos;
        beats1_r  <= v1.beats;
        beats2_r  <= v2.beats;
        smp1_r    <= smp1_nxt;
        smp2_r    <= smp2_nxt;
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_req_r   <= in_data.req_type;
      s1_start_r <= start_b;
      s1_adv_r   <= play_nxt;
      s1_nxt1_r  <= nxt1;
      s1_nxt2_r  <= nxt2;
    end
    if (s2_go) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Two-voice wavetable sequencer testbench
// Fills the opening song entries and the wave memory, runs short directed
// checks of note stepping, button debounce, sample mixing and unused
// requests, then random traffic over several register settings. Every result
// beat is checked against a cycle-free prediction of the sequencer state,
// with random idle cycles on the input side and random stalls on the output.
// ----------------------------------------------------------------------------
module tb;
  import tws_pkg::*;

  localparam int REQ_SPARE_FIRST = 5;
  localparam int REQ_SPARE_LAST  = 7;
  localparam int WAVE_WORDS      = NUM_INSTRUMENTS_DEF * WAVE_LENGTH_DEF;
  localparam int SONG_FILL       = 32;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  note_t                 tune_a [SONG_DEPTH_DEF];
  note_t                 tune_b [SONG_DEPTH_DEF];
  logic [SAMPLE_W-1:0]   wave_mem [WAVE_WORDS];
  logic [LEN_W-1:0]      span_a = SONG_LEN_RST;
  logic [LEN_W-1:0]      span_b = SONG_LEN_RST;
  logic [DBN_W-1:0]      hold_ticks = DEBOUNCE_RST;
  logic                  playing = 1'b1;
  logic                  running = 1'b0;
  logic [INST_W-1:0]     voice_inst = '0;
  logic [DBN_W-1:0]      btn_timer [NUM_BUTTONS_DEF] = '{default: '0};
  logic [NIDX_W-1:0]     at_a = '0;
  logic [NIDX_W-1:0]     at_b = '0;
  logic [BEATS_W-1:0]    left_a = '0;
  logic [BEATS_W-1:0]    left_b = '0;
  logic [WIDX_W-1:0]     ph_a = '0;
  logic [WIDX_W-1:0]     ph_b = '0;
  logic [SAMPLE_W-1:0]   tap_a = '0;
  logic [SAMPLE_W-1:0]   tap_b = '0;

  out_beat_t             out_due [$];
  int                    mismatches = 0;
  bit                    calm = 1'b0;

  two_voice_wavetable_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 22);
  end

  function automatic int song_span(input logic [LEN_W-1:0] len);
    if (len == '0) return 1;
    if (int'(len) > SONG_DEPTH_DEF) return SONG_DEPTH_DEF;
    return int'(len);
  endfunction

  // A beat may move each voice one note on; it is sent only while that note is loaded.
  function automatic bit beat_in_fill();
    int na;
    int nb;
    na = (int'(at_a) + 1 >= song_span(span_a)) ? 0 : int'(at_a) + 1;
    nb = (int'(at_b) + 1 >= song_span(span_b)) ? 0 : int'(at_b) + 1;
    return (na < SONG_FILL) && (nb < SONG_FILL);
  endfunction

  function automatic bit voice_advance(input bit second, output logic [PERIOD_W-1:0] reload);
    logic [NIDX_W-1:0]  at;
    logic [BEATS_W-1:0] left;
    note_t              entry;
    int                 span;
    at = second ? at_b : at_a;
    left = (second ? left_b : left_a) - BEATS_W'(1);
    span = song_span(second ? span_b : span_a);
    reload = '0;
    voice_advance = 1'b0;
    if (left == '0) begin
      at = (int'(at) + 1 >= span) ? '0 : at + NIDX_W'(1);
      entry = second ? tune_b[at] : tune_a[at];
      left = entry.beats;
      reload = entry.period - PERIOD_W'(1);
      voice_advance = 1'b1;
    end
    if (second) begin
      at_b = at;
      left_b = left;
    end else begin
      at_a = at;
      left_a = left;
    end
  endfunction

  function automatic out_beat_t sequencer_step(input in_beat_t b);
    out_beat_t           r;
    logic [PERIOD_W-1:0] rl;
    logic [SAMPLE_W:0]   mix;
    int                  base;
    r = '0;
    base = int'(voice_inst) * WAVE_LENGTH_DEF;
    case (b.req_type)
      REQ_BEAT: begin
        for (int i = 0; i < NUM_BUTTONS_DEF; i++)
          if (b.buttons[i]) btn_timer[i] = hold_ticks;
        for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
          if (btn_timer[i] != '0) begin
            btn_timer[i] = btn_timer[i] - DBN_W'(1);
            if (btn_timer[i] == '0) begin
              if (i == BTN_PLAY) playing = ~playing;
              else if (i == BTN_RESTART) running = 1'b0;
              else if (i == BTN_INSTR)
                voice_inst = (voice_inst == INST_W'(NUM_INSTRUMENTS_DEF - 1)) ?
                             '0 : voice_inst + INST_W'(1);
            end
          end
        end
        if (playing && !running) begin
          running = 1'b1;
          at_a = '0;
          at_b = '0;
          left_a = tune_a[0].beats;
          left_b = tune_b[0].beats;
          r.reload1_valid = 1'b1;
          r.reload1_value = tune_a[0].period - PERIOD_W'(1);
          r.reload2_valid = 1'b1;
          r.reload2_value = tune_b[0].period - PERIOD_W'(1);
        end
        if (playing && running) begin
          if (voice_advance(1'b0, rl)) begin
            r.reload1_valid = 1'b1;
            r.reload1_value = rl;
          end
          if (voice_advance(1'b1, rl)) begin
            r.reload2_valid = 1'b1;
            r.reload2_value = rl;
          end
        end
      end
      REQ_V1, REQ_V2: begin
        if (b.req_type == REQ_V1) begin
          ph_a = ph_a + WIDX_W'(1);
          tap_a = wave_mem[base + int'(ph_a)];
        end else begin
          ph_b = ph_b + WIDX_W'(1);
          tap_b = wave_mem[base + int'(ph_b)] >> 1;
        end
        mix = {1'b0, tap_a} + {1'b0, tap_b};
        r.dac_valid = 1'b1;
        r.dac_value = playing ? mix[SAMPLE_W:1] : '0;
      end
      REQ_NOTE: begin
        if (b.note_voice) tune_b[b.note_index] = {b.note_period, b.note_beats};
        else tune_a[b.note_index] = {b.note_period, b.note_beats};
      end
      REQ_WAVE: begin
        if (int'(b.wave_instrument) < NUM_INSTRUMENTS_DEF)
          wave_mem[int'(b.wave_instrument) * WAVE_LENGTH_DEF + int'(b.wave_index)] =
            b.wave_sample;
      end
      default: ;
    endcase
    r.play_on = playing;
    r.instrument_now = voice_inst;
    return r;
  endfunction

  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 22) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    out_due.push_back(sequencer_step(b));
  endtask

  task automatic send_req(input logic [REQ_W-1:0] req, input logic [BTN_W-1:0] btns);
    in_beat_t b;
    b = {$urandom, $urandom};
    b.req_type = req;
    b.buttons = btns;
    send_beat(b);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (out_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SONG1_LEN: span_a = val;
      CFG_SONG2_LEN: span_b = val;
      CFG_DEBOUNCE:  hold_ticks = val[DBN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 7))
      0: pick_len = '0;
      1: pick_len = LEN_W'(1);
      2: pick_len = LEN_W'(SONG_DEPTH_DEF);
      3: pick_len = LEN_W'(SONG_DEPTH_DEF + 1);
      4: pick_len = '1;
      default: pick_len = LEN_W'($urandom_range(2, 12));
    endcase
  endfunction

  task automatic test_fill_memories();
    in_beat_t b;
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < SONG_FILL; i++) begin
        b = {$urandom, $urandom};
        b.req_type = REQ_NOTE;
        b.note_voice = v[0];
        b.note_index = NIDX_W'(i);
        b.note_beats = BEATS_W'($urandom_range(1, 3));
        send_beat(b);
      end
    end
    for (int i = 0; i < WAVE_WORDS; i++) begin
      b = {$urandom, $urandom};
      b.req_type = REQ_WAVE;
      b.wave_instrument = INST_W'(i / WAVE_LENGTH_DEF);
      b.wave_index = WIDX_W'(i % WAVE_LENGTH_DEF);
      send_beat(b);
    end
  endtask

  task automatic test_note_stepping();
    in_beat_t b;
    b = {$urandom, $urandom};
    b.req_type = REQ_NOTE;
    b.note_voice = 1'b0;
    b.note_index = NIDX_W'(1);
    b.note_period = '1;
    b.note_beats = BEATS_W'(1);
    send_beat(b);
    b.note_index = NIDX_W'(2);
    b.note_period = '0;
    b.note_beats = '0;
    send_beat(b);
    b.note_voice = 1'b1;
    b.note_index = NIDX_W'(1);
    b.note_beats = BEATS_W'(2);
    send_beat(b);
    settle();
    write_reg(CFG_SONG1_LEN, CFG_DATA_W'(3));
    write_reg(CFG_SONG2_LEN, CFG_DATA_W'(2));
    write_reg(CFG_DEBOUNCE, CFG_DATA_W'(1));
    repeat (6) send_req(REQ_BEAT, '0);
  endtask

  task automatic test_buttons();
    send_req(REQ_BEAT, BTN_W'(1 << BTN_INSTR));
    send_req(REQ_BEAT, BTN_W'(1 << BTN_PLAY));
    send_req(REQ_V1, '0);
    send_req(REQ_BEAT, BTN_W'(1 << BTN_PLAY));
    send_req(REQ_BEAT, BTN_W'(1 << BTN_RESTART));
    send_req(REQ_BEAT, '1);
    send_req(REQ_BEAT, BTN_W'(1 << (NUM_BUTTONS_DEF - 1)));
    send_req(REQ_BEAT, BTN_W'(1 << BTN_PLAY));
    settle();
    write_reg(CFG_DEBOUNCE, '0);
    send_req(REQ_BEAT, BTN_W'(1 << BTN_PLAY));
  endtask

  task automatic test_sample_mix();
    in_beat_t b;
    b = {$urandom, $urandom};
    b.req_type = REQ_WAVE;
    b.wave_instrument = voice_inst;
    b.wave_index = ph_a + WIDX_W'(1);
    b.wave_sample = '1;
    send_beat(b);
    b.wave_index = ph_b + WIDX_W'(1);
    b.wave_sample = '0;
    send_beat(b);
    b.wave_instrument = INST_W'(NUM_INSTRUMENTS_DEF);
    b.wave_sample = '1;
    send_beat(b);
    send_req(REQ_V1, '0);
    send_req(REQ_V2, '0);
    send_req(REQ_V2, '0);
  endtask

  task automatic test_spare_requests();
    for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++) send_req(REQ_W'(c), '1);
  endtask

  task automatic test_random_traffic();
    in_beat_t b;
    int       sel;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_reg(CFG_SONG1_LEN, (ph == 0) ? LEN_W'(SONG_DEPTH_DEF) :
                               (ph == 1) ? '0 : pick_len());
      write_reg(CFG_SONG2_LEN, (ph == 0) ? '1 : (ph == 1) ? '0 : pick_len());
      write_reg(CFG_DEBOUNCE, (ph == 0) ? CFG_DATA_W'(7) : CFG_DATA_W'($urandom));
      calm = (ph == 2);
      for (int n = 0; n < 36; n++) begin
        b = {$urandom, $urandom};
        sel = $urandom_range(0, 99);
        if (sel < 40 && beat_in_fill()) begin
          b.req_type = REQ_BEAT;
          if ($urandom_range(0, 99) >= 6) b.buttons = '0;
        end else if (sel < 75) begin
          b.req_type = sel[0] ? REQ_V1 : REQ_V2;
        end else if (sel < 88) begin
          b.req_type = REQ_NOTE;
          if ($urandom_range(0, 3) != 0) b.note_index = NIDX_W'($urandom_range(0, SONG_FILL - 1));
          if ($urandom_range(0, 9) < 8) b.note_beats = BEATS_W'($urandom_range(1, 4));
        end else if (sel < 97) begin
          b.req_type = REQ_WAVE;
        end else begin
          b.req_type = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        end
        send_beat(b);
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin : check_out
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (out_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected: %h", out_data);
      end else begin
        want = out_due.pop_front();
        if (out_data.dac_valid !== want.dac_valid ||
            out_data.dac_value !== want.dac_value ||
            out_data.reload1_valid !== want.reload1_valid ||
            out_data.reload1_value !== want.reload1_value ||
            out_data.reload2_valid !== want.reload2_valid ||
            out_data.reload2_value !== want.reload2_value ||
            out_data.play_on !== want.play_on ||
            out_data.instrument_now !== want.instrument_now) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("expected dac %0d:%h r1 %0d:%h r2 %0d:%h play %0d inst %0d",
                     want.dac_valid, want.dac_value, want.reload1_valid,
                     want.reload1_value, want.reload2_valid, want.reload2_value,
                     want.play_on, want.instrument_now);
            $display("actual   dac %0d:%h r1 %0d:%h r2 %0d:%h play %0d inst %0d",
                     out_data.dac_valid, out_data.dac_value, out_data.reload1_valid,
                     out_data.reload1_value, out_data.reload2_valid,
                     out_data.reload2_value, out_data.play_on, out_data.instrument_now);
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_fill_memories();
    test_note_stepping();
    test_buttons();
    test_sample_mix();
    test_spare_requests();
    test_random_traffic();
    settle();
    if (mismatches == 0 && out_due.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
